>>> rtl/core/voice_effect_chain_core_assert.svh
// Assertion macros used by the checker file of the voice effect core.
`ifndef VOICE_EFFECT_CHAIN_CORE_ASSERT_SVH
`define VOICE_EFFECT_CHAIN_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VEC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define VEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Delayed implication, disabled while reset is asserted.
`define VEC_ASSERT_LATER2(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/vec_pkg.sv
// ----------------------------------------------------------------------------
// vec_pkg
// Shared types and constants of the voice effect core.
// ----------------------------------------------------------------------------
package vec_pkg;

    typedef enum logic [1:0] {
        MODE_PASS   = 2'd0,
        MODE_NOISE  = 2'd1,
        MODE_WALKIE = 2'd2,
        MODE_VOICE  = 2'd3
    } mode_t;

    localparam int SAMPLE_W = 16;
    localparam int MODE_W   = 2;

    localparam int NOISE_OFFSET = 32768;
    localparam int NOISE_SCALE  = 3277;

    localparam int RADIO_STATE_W  = 24;
    localparam int RADIO_FB_MUL   = 31;
    localparam int RADIO_GATE     = 300;
    localparam int RADIO_KNEE     = 12000;
    localparam int RADIO_CLIP     = 18000;
    localparam int RADIO_DITHER_C = 3;

    localparam int VOICE_GAIN_W     = 3;
    localparam int VOICE_GAIN_RESET = 2;
    localparam int VOICE_GAIN_MIN   = 1;
    localparam int VOICE_GAIN_MAX   = 6;
    localparam int VOICE_AGC_HIGH   = 12000;
    localparam int VOICE_AGC_LOW    = 3000;
    localparam int VOICE_KNEE       = 14000;
    localparam int VOICE_CLIP       = 16000;

endpackage

>>> rtl/core/vec_channels.sv
// ----------------------------------------------------------------------------
// vec_channels
// Valid/ready channel interfaces for samples, results and configuration.
// ----------------------------------------------------------------------------
interface vec_sample_if;
    logic                 valid;
    logic                 ready;
    logic signed [15:0]   sample_in;
    logic        [15:0]   random_word;

    modport source (output valid, output sample_in, output random_word, input ready);
    modport sink   (input valid, input sample_in, input random_word, output ready);
endinterface

interface vec_result_if;
    logic                 valid;
    logic                 ready;
    logic signed [15:0]   sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface vec_cfg_if;
    logic                 valid;
    logic                 ready;
    logic        [1:0]    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/voice_effect_chain_core.sv
// ----------------------------------------------------------------------------
// voice_effect_chain_core
// Per-sample voice effect selected by a mode register.
// ----------------------------------------------------------------------------
// The core takes one sample request per clock unless a stalled result backs
// it up, and returns one result per request, in order. A request lands in the
// input register, the selected effect chain runs through combinational logic,
// and the result register captures its output as the input register advances.
// Throughput is one sample per clock while results are taken, set by the input
// and result registers; a stalled result holds the input register, and a new
// request is still taken whenever the input register is empty or moving
// forward. Each effect's filter state advances only when one of its samples
// moves into the result register. Write the mode only while idle.
module voice_effect_chain_core (
    input  logic      clk,
    input  logic      rst_n,
    vec_sample_if.sink   samples,
    vec_result_if.source results,
    vec_cfg_if.sink      cfg
);

    vec_pkg::mode_t     mode_reg;

    logic               in_valid_reg;
    logic signed [15:0] x_reg;
    logic        [15:0] r_reg;
    logic               out_valid_reg;
    logic signed [15:0] y_reg;

    logic               advance;
    logic               accept;
    logic signed [15:0] y_next;
    logic signed [15:0] y_noise;
    logic signed [15:0] y_radio;
    logic signed [15:0] y_voice;
    logic               radio_en;
    logic               voice_en;

    assign advance        = in_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready  = !in_valid_reg || advance;
    assign accept         = samples.valid && samples.ready;
    assign cfg.ready      = 1'b1;
    assign results.valid  = out_valid_reg;
    assign results.sample_out = y_reg;

    assign radio_en = advance && (mode_reg == vec_pkg::MODE_WALKIE);
    assign voice_en = advance && (mode_reg == vec_pkg::MODE_VOICE);

    vec_noise u_noise (
        .r (r_reg),
        .y (y_noise)
    );

    vec_radio u_radio (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (radio_en),
        .x     (x_reg),
        .r     (r_reg[2:0]),
        .y     (y_radio)
    );

    vec_voice u_voice (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (voice_en),
        .x     (x_reg),
        .r     (r_reg),
        .y     (y_voice)
    );

    always_comb
    begin
        case (mode_reg)
            vec_pkg::MODE_NOISE:  y_next = y_noise;
            vec_pkg::MODE_WALKIE: y_next = y_radio;
            vec_pkg::MODE_VOICE:  y_next = y_voice;
            default:              y_next = x_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= vec_pkg::MODE_PASS;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                mode_reg <= vec_pkg::mode_t'(cfg.data);

            // hold the input register while the result stalls
            if (accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= samples.sample_in;
            r_reg <= samples.random_word;
        end
        if (advance)
            y_reg <= y_next;
    end

endmodule

>>> rtl/core/vec_noise.sv
// ----------------------------------------------------------------------------
// vec_noise
// Scaled white noise from the random word, truncated toward zero.
// ----------------------------------------------------------------------------
module vec_noise (
    input  logic        [15:0] r,
    output logic signed [15:0] y
);

    logic signed [16:0] v;
    logic signed [28:0] p;
    logic signed [28:0] p_adj;

    always_comb
    begin
        v     = $signed({1'b0, r}) - 17'sd32768;
        p     = 29'(v) * 29'(vec_pkg::NOISE_SCALE);
        // bias negative products so the shift rounds toward zero
        p_adj = p + (p[28] ? 29'sd65535 : 29'sd0);
        y     = 16'(p_adj >>> 16);
    end

endmodule

>>> rtl/core/vec_radio.sv
// ----------------------------------------------------------------------------
// vec_radio
// Radio voice chain: leaky high-pass, low-pass, gate, gain, knee, clip, dither.
// ----------------------------------------------------------------------------
module vec_radio (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic signed [15:0] x,
    input  logic        [2:0]  r,
    output logic signed [15:0] y
);

    logic signed [15:0] last_in_reg;
    logic signed [23:0] last_hp_reg;
    logic signed [23:0] acc_reg;
    logic signed [23:0] last_hp_next;
    logic signed [23:0] acc_next;

    logic signed [29:0] fb_mul;
    logic signed [29:0] hp_full;
    logic signed [24:0] diff;
    logic signed [24:0] acc_full;
    logic signed [25:0] y_gain;
    logic signed [25:0] y_knee;
    logic signed [25:0] y_clip;
    logic signed [4:0]  dith;

    always_comb
    begin
        fb_mul       = 30'(last_hp_reg) * 30'(vec_pkg::RADIO_FB_MUL);
        hp_full      = 30'(x) - 30'(last_in_reg) + (fb_mul >>> 5);
        last_hp_next = hp_full[23:0];
        diff         = 25'(last_hp_next) - 25'(acc_reg);
        acc_full     = 25'(acc_reg) + (diff >>> 3);
        acc_next     = acc_full[23:0];

        // gate small values, then gain of four
        if (acc_next > -vec_pkg::RADIO_GATE && acc_next < vec_pkg::RADIO_GATE)
            y_gain = 26'sd0;
        else
            y_gain = {acc_next, 2'b00};

        if (y_gain > vec_pkg::RADIO_KNEE)
            y_knee = 26'(vec_pkg::RADIO_KNEE) + ((y_gain - 26'(vec_pkg::RADIO_KNEE)) >>> 3);
        else if (y_gain < -vec_pkg::RADIO_KNEE)
            y_knee = -26'(vec_pkg::RADIO_KNEE) + ((y_gain + 26'(vec_pkg::RADIO_KNEE)) >>> 3);
        else
            y_knee = y_gain;

        if (y_knee > vec_pkg::RADIO_CLIP)
            y_clip = 26'(vec_pkg::RADIO_CLIP);
        else if (y_knee < -vec_pkg::RADIO_CLIP)
            y_clip = -26'(vec_pkg::RADIO_CLIP);
        else
            y_clip = y_knee;

        dith = $signed({2'b00, r}) - 5'(vec_pkg::RADIO_DITHER_C);
        // dither only nonzero samples
        if (y_clip != 26'sd0)
            y = 16'(y_clip + 26'(dith));
        else
            y = 16'sd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_in_reg <= '0;
            last_hp_reg <= '0;
            acc_reg     <= '0;
        end
        else if (en)
        begin
            last_in_reg <= x;
            last_hp_reg <= last_hp_next;
            acc_reg     <= acc_next;
        end
    end

endmodule

>>> rtl/core/vec_voice.sv
// ----------------------------------------------------------------------------
// vec_voice
// Loud voice chain: difference high-pass, boost, AGC, knee, clip, dither.
// ----------------------------------------------------------------------------
module vec_voice (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic signed [15:0] x,
    input  logic        [15:0] r,
    output logic signed [15:0] y
);

    // remainder by three: base-4 digits sum to the same residue
    function automatic logic [1:0] mod3_16(input logic [15:0] v);
        logic [4:0] s;
        logic [2:0] t;
        logic [1:0] m;
        s = '0;
        for (int i = 0; i < 8; i++)
            s = s + 5'(v[2*i +: 2]);
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        case (t)
            3'd1, 3'd4, 3'd7: m = 2'd1;
            3'd2, 3'd5:       m = 2'd2;
            default:          m = 2'd0;
        endcase
        return m;
    endfunction

    logic signed [15:0] last_in_reg;
    logic        [2:0]  gain_reg;
    logic        [2:0]  gain_next;

    logic signed [16:0] d;
    logic signed [16:0] half;
    logic signed [17:0] y_boost;
    logic signed [17:0] mag;
    logic        [3:0]  g_step;
    logic signed [20:0] y_gain;
    logic signed [20:0] t_over;
    logic signed [20:0] y_knee;
    logic signed [20:0] y_clip;
    logic signed [2:0]  dith;

    always_comb
    begin
        d       = 17'(x) - 17'(last_in_reg);
        // halve toward zero
        half    = (d + (d[16] ? 17'sd1 : 17'sd0)) >>> 1;
        y_boost = 18'(d) + 18'(half);
        mag     = y_boost[17] ? -y_boost : y_boost;

        if (mag > vec_pkg::VOICE_AGC_HIGH)
            g_step = {1'b0, gain_reg} - 4'd1;
        else if (mag < vec_pkg::VOICE_AGC_LOW)
            g_step = {1'b0, gain_reg} + 4'd1;
        else
            g_step = {1'b0, gain_reg};

        if (g_step < 4'(vec_pkg::VOICE_GAIN_MIN))
            gain_next = 3'(vec_pkg::VOICE_GAIN_MIN);
        else if (g_step > 4'(vec_pkg::VOICE_GAIN_MAX))
            gain_next = 3'(vec_pkg::VOICE_GAIN_MAX);
        else
            gain_next = g_step[2:0];

        y_gain = 21'(y_boost) * $signed({18'b0, gain_next});

        if (y_gain > vec_pkg::VOICE_KNEE)
        begin
            t_over = y_gain - 21'(vec_pkg::VOICE_KNEE);
            y_knee = 21'(vec_pkg::VOICE_KNEE) + (t_over >>> 2);
        end
        else if (y_gain < -vec_pkg::VOICE_KNEE)
        begin
            t_over = y_gain + 21'(vec_pkg::VOICE_KNEE);
            // quarter toward zero
            y_knee = -21'(vec_pkg::VOICE_KNEE) + ((t_over + 21'sd3) >>> 2);
        end
        else
        begin
            t_over = '0;
            y_knee = y_gain;
        end

        if (y_knee > vec_pkg::VOICE_CLIP)
            y_clip = 21'(vec_pkg::VOICE_CLIP);
        else if (y_knee < -vec_pkg::VOICE_CLIP)
            y_clip = -21'(vec_pkg::VOICE_CLIP);
        else
            y_clip = y_knee;

        dith = $signed({1'b0, mod3_16(r)}) - 3'sd1;
        y    = 16'(y_clip + 21'(dith));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_in_reg <= '0;
            gain_reg    <= 3'(vec_pkg::VOICE_GAIN_RESET);
        end
        else if (en)
        begin
            last_in_reg <= x;
            gain_reg    <= gain_next;
        end
    end

endmodule

>>> rtl/core/vec_checker.sv
// ----------------------------------------------------------------------------
// vec_checker
// Port-level checks of the voice effect core, bound to the top level.
// ----------------------------------------------------------------------------
`include "voice_effect_chain_core_assert.svh"

module vec_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_data,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // a stalled result holds its value
    `VEC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

    // request side only backs up behind a stalled result
    `VEC_ASSERT_NOW(a_in_backpressure, clk, rst_n, !in_ready, out_valid && !out_ready)

    // every accepted request is followed by a valid result in the result register
    `VEC_ASSERT_LATER2(a_in_to_out, clk, rst_n, in_valid && in_ready, out_valid)

    // configuration writes are never refused
    `VEC_ASSERT_NOW(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind voice_effect_chain_core vec_checker u_vec_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (results.sample_out),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready)
);
